// ===== src/triangle_barycentric_rasterizer_defines.svh =====
`ifndef TRIANGLE_BARYCENTRIC_RASTERIZER_DEFINES_SVH
`define TRIANGLE_BARYCENTRIC_RASTERIZER_DEFINES_SVH

// implication in the same cycle
`define TBR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

// implication in the next cycle
`define TBR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/tbr_pkg.sv =====
package tbr_pkg;

    localparam int IMG_W     = 512;
    localparam int IMG_H     = 512;
    localparam int FRAC_BITS = 4;

    localparam int CW  = 13;
    localparam int PW  = 9;
    localparam int COLW = 24;
    localparam int VW  = 30;
    localparam int MW  = 18;
    localparam int WW  = 17;
    localparam int BW  = 5;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    typedef struct packed {
        logic [PW-1:0] x;
        logic [PW-1:0] y;
        logic          last;
    } t_pix;

    typedef struct packed {
        logic [2:0][CW-1:0]   x;
        logic [2:0][CW-1:0]   y;
        logic [2:0][COLW-1:0] c;
        logic                 smooth;
    } t_tri;

    typedef struct packed {
        logic valid;
        logic full;
    } t_qstat;

endpackage

// ===== src/triangle_barycentric_rasterizer.sv =====
// vertex load: accepted only once the queue and the shading sequencer are drained, so it
// waits while earlier pixels are still in flight; advance: accepted while the pixel queue
// is not full, so the box walk can run ahead of shading; each pixel is shaded in turn by
// the shared multiplier sequence (16 products, 4 when degenerate, 9 more for smooth colour)
// and the one-bit-per-cycle weight divider (51 steps); a two-entry pixel queue separates the
// box walk from the shading sequencer; reset: synchronous active low, clears vertices, walk,
// queue and result valid flag
module triangle_barycentric_rasterizer (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_cmd,
    input  logic [1:0]             i_vertex_index,
    input  logic [tbr_pkg::CW-1:0] i_coord_x,
    input  logic [tbr_pkg::CW-1:0] i_coord_y,
    input  logic [7:0]             i_red_in,
    input  logic [7:0]             i_green_in,
    input  logic [7:0]             i_blue_in,
    input  logic                   i_smooth,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [tbr_pkg::PW-1:0] o_pixel_x,
    output logic [tbr_pkg::PW-1:0] o_pixel_y,
    output logic                   o_covered,
    output logic [7:0]             o_red_out,
    output logic [7:0]             o_green_out,
    output logic [7:0]             o_blue_out,
    output logic                   o_last_pixel
);

    tbr_pkg::t_qstat w_qstat;
    tbr_pkg::t_pix   w_push_pix, w_pop_pix;
    tbr_pkg::t_tri   w_tri;
    logic            w_push, w_pop, w_idle;

    tbr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_vertex_index (i_vertex_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_red_in       (i_red_in),
        .i_green_in     (i_green_in),
        .i_blue_in      (i_blue_in),
        .i_smooth       (i_smooth),
        .i_qstat        (w_qstat),
        .i_drained      (!w_qstat.valid && w_idle),
        .o_push         (w_push),
        .o_pix          (w_push_pix),
        .o_tri          (w_tri)
    );

    tbr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pix   (w_push_pix),
        .i_pop   (w_pop),
        .o_pix   (w_pop_pix),
        .o_stat  (w_qstat)
    );

    tbr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tri        (w_tri),
        .i_pix        (w_pop_pix),
        .i_qstat      (w_qstat),
        .o_pop        (w_pop),
        .o_idle       (w_idle),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_covered    (o_covered),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_last_pixel (o_last_pixel)
    );

endmodule

// ===== src/tbr_front.sv =====
module tbr_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_cmd,
    input  logic [1:0]             i_vertex_index,
    input  logic [tbr_pkg::CW-1:0] i_coord_x,
    input  logic [tbr_pkg::CW-1:0] i_coord_y,
    input  logic [7:0]             i_red_in,
    input  logic [7:0]             i_green_in,
    input  logic [7:0]             i_blue_in,
    input  logic                   i_smooth,
    input  tbr_pkg::t_qstat        i_qstat,
    input  logic                   i_drained,
    output logic                   o_push,
    output tbr_pkg::t_pix          o_pix,
    output tbr_pkg::t_tri          o_tri
);

    localparam int  CW = tbr_pkg::CW;
    localparam int  PW = tbr_pkg::PW;
    localparam int  EW = CW + 1;
    localparam logic [EW-1:0] UP   = EW'((1 << tbr_pkg::FRAC_BITS) - 1);
    localparam logic [EW-1:0] XLIM = EW'(tbr_pkg::IMG_W - 1);
    localparam logic [EW-1:0] YLIM = EW'(tbr_pkg::IMG_H - 1);

    tbr_pkg::t_tri r_tri;
    logic [PW-1:0] r_xmin, r_xmax, r_ymin, r_ymax, r_wx, r_wy;
    logic          r_active;

    logic          w_acc, w_last;
    logic [CW-1:0] w_x0, w_x1, w_x2, w_y0, w_y1, w_y2;
    logic [CW-1:0] w_xmn, w_xmx, w_ymn, w_ymx;
    logic [EW-1:0] w_bx0, w_bx1, w_by0, w_by1;

    assign o_stall = (i_cmd == tbr_pkg::CMD_ADVANCE) ? i_qstat.full : !i_drained;
    assign w_acc   = i_valid && !o_stall;
    assign w_last  = (r_wx == r_xmax) && (r_wy == r_ymax);
    assign o_push  = w_acc && (i_cmd == tbr_pkg::CMD_ADVANCE) && r_active;
    assign o_pix   = '{x: r_wx, y: r_wy, last: w_last};
    assign o_tri   = r_tri;

    // bounds with the incoming vertex 2
    always_comb begin
        w_x0 = r_tri.x[0];
        w_x1 = r_tri.x[1];
        w_x2 = i_coord_x;
        w_y0 = r_tri.y[0];
        w_y1 = r_tri.y[1];
        w_y2 = i_coord_y;
        w_xmn = w_x0;
        w_xmx = w_x0;
        w_ymn = w_y0;
        w_ymx = w_y0;
        if (w_x1 < w_xmn) w_xmn = w_x1;
        if (w_x2 < w_xmn) w_xmn = w_x2;
        if (w_x1 > w_xmx) w_xmx = w_x1;
        if (w_x2 > w_xmx) w_xmx = w_x2;
        if (w_y1 < w_ymn) w_ymn = w_y1;
        if (w_y2 < w_ymn) w_ymn = w_y2;
        if (w_y1 > w_ymx) w_ymx = w_y1;
        if (w_y2 > w_ymx) w_ymx = w_y2;
        w_bx0 = EW'(w_xmn) >> tbr_pkg::FRAC_BITS;
        w_bx1 = (EW'(w_xmx) + UP) >> tbr_pkg::FRAC_BITS;
        w_by0 = EW'(w_ymn) >> tbr_pkg::FRAC_BITS;
        w_by1 = (EW'(w_ymx) + UP) >> tbr_pkg::FRAC_BITS;
        if (w_bx0 > XLIM) w_bx0 = XLIM;
        if (w_bx1 > XLIM) w_bx1 = XLIM;
        if (w_by0 > YLIM) w_by0 = YLIM;
        if (w_by1 > YLIM) w_by1 = YLIM;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tri    <= '0;
            r_xmin   <= '0;
            r_xmax   <= '0;
            r_ymin   <= '0;
            r_ymax   <= '0;
            r_wx     <= '0;
            r_wy     <= '0;
            r_active <= 1'b0;
        end else if (w_acc && (i_cmd == tbr_pkg::CMD_LOAD) && (i_vertex_index != 2'd3)) begin
            r_tri.x[i_vertex_index] <= i_coord_x;
            r_tri.y[i_vertex_index] <= i_coord_y;
            r_tri.c[i_vertex_index] <= {i_red_in, i_green_in, i_blue_in};
            if (i_vertex_index == 2'd0) begin
                r_tri.smooth <= i_smooth;
            end
            if (i_vertex_index == 2'd2) begin
                r_xmin   <= PW'(w_bx0);
                r_xmax   <= PW'(w_bx1);
                r_ymin   <= PW'(w_by0);
                r_ymax   <= PW'(w_by1);
                r_wx     <= PW'(w_bx0);
                r_wy     <= PW'(w_by0);
                r_active <= 1'b1;
            end else begin
                r_active <= 1'b0;
            end
        end else if (o_push) begin
            if (w_last) begin
                r_active <= 1'b0;
            end else if (r_wx >= r_xmax) begin
                r_wx <= r_xmin;
                r_wy <= r_wy + 1'b1;
            end else begin
                r_wx <= r_wx + 1'b1;
            end
        end
    end

endmodule

// ===== src/tbr_queue.sv =====
module tbr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tbr_pkg::t_pix   i_pix,
    input  logic            i_pop,
    output tbr_pkg::t_pix   o_pix,
    output tbr_pkg::t_qstat o_stat
);

    tbr_pkg::t_pix r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    assign o_pix        = r_mem[r_rp];
    assign o_stat.valid = (r_cnt != 2'd0);
    assign o_stat.full  = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== src/tbr_back.sv =====
`include "triangle_barycentric_rasterizer_defines.svh"

module tbr_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tbr_pkg::t_tri          i_tri,
    input  tbr_pkg::t_pix          i_pix,
    input  tbr_pkg::t_qstat        i_qstat,
    output logic                   o_pop,
    output logic                   o_idle,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [tbr_pkg::PW-1:0] o_pixel_x,
    output logic [tbr_pkg::PW-1:0] o_pixel_y,
    output logic                   o_covered,
    output logic [7:0]             o_red_out,
    output logic [7:0]             o_green_out,
    output logic [7:0]             o_blue_out,
    output logic                   o_last_pixel
);

    localparam int CW = tbr_pkg::CW;
    localparam int PW = tbr_pkg::PW;
    localparam int VW = tbr_pkg::VW;
    localparam int MW = tbr_pkg::MW;
    localparam int WW = tbr_pkg::WW;
    localparam int BW = tbr_pkg::BW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_CMUL = 3'd4;
    localparam logic [2:0] S_CACC = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    localparam logic [BW-1:0] TOPBIT = BW'(WW - 1);

    logic [2:0]             r_state;
    logic [1:0]             r_pass, r_term, r_j, r_ch;
    logic [PW-1:0]          r_px, r_py;
    logic                   r_last, r_cov, r_neg;
    logic signed [2*MW-1:0] r_prod;
    logic signed [VW-1:0]   r_acc, r_c, r_aa;
    logic signed [VW-1:0]   r_e [3];
    logic [VW-1:0]          r_rem;
    logic [WW-1:0]          r_q;
    logic [WW-1:0]          r_w [3];
    logic [BW-1:0]          r_bit;
    logic [7:0]             r_rgb [3];
    logic                   r_ov;
    logic [PW-1:0]          r_ox, r_oy;
    logic                   r_ocov, r_olast;
    logic [7:0]             r_or, r_og, r_ob;

    logic [1:0]             w_ai, w_ci;
    logic [CW-1:0]          w_xa, w_ya, w_xc, w_yc, w_ptx, w_pty;
    logic signed [MW-1:0]   w_a, w_b, w_m1, w_m2;
    logic signed [VW-1:0]   w_prod, w_val, w_tie, w_e, w_t;
    logic [7:0]             w_col;
    logic [VW:0]            w_x;
    logic                   w_ge, w_ok;

    always_comb begin
        case (r_pass)
            2'd2:    begin w_ai = 2'd2; w_ci = 2'd0; end
            2'd3:    begin w_ai = 2'd0; w_ci = 2'd1; end
            default: begin w_ai = 2'd1; w_ci = 2'd2; end
        endcase
        w_xa  = i_tri.x[w_ai];
        w_ya  = i_tri.y[w_ai];
        w_xc  = i_tri.x[w_ci];
        w_yc  = i_tri.y[w_ci];
        w_a   = MW'($signed({1'b0, w_ya})) - MW'($signed({1'b0, w_yc}));
        w_b   = MW'($signed({1'b0, w_xc})) - MW'($signed({1'b0, w_xa}));
        w_ptx = (r_pass == 2'd0) ? i_tri.x[0] : (CW'(r_px) << tbr_pkg::FRAC_BITS);
        w_pty = (r_pass == 2'd0) ? i_tri.y[0] : (CW'(r_py) << tbr_pkg::FRAC_BITS);
        case (r_ch)
            2'd0:    w_col = i_tri.c[r_j][23:16];
            2'd1:    w_col = i_tri.c[r_j][15:8];
            default: w_col = i_tri.c[r_j][7:0];
        endcase
        if (r_state == S_CMUL) begin
            w_m1 = $signed(MW'(r_w[r_j]));
            w_m2 = $signed(MW'(w_col));
        end else begin
            case (r_term)
                2'd0:    begin w_m1 = $signed(MW'(w_xa)); w_m2 = $signed(MW'(w_yc)); end
                2'd1:    begin w_m1 = $signed(MW'(w_xc)); w_m2 = $signed(MW'(w_ya)); end
                2'd2:    begin w_m1 = w_a; w_m2 = $signed(MW'(w_ptx)); end
                default: begin w_m1 = w_b; w_m2 = $signed(MW'(w_pty)); end
            endcase
        end
        w_prod = VW'(r_prod);
        case (r_term)
            2'd0:    w_val = w_prod;
            2'd1:    w_val = r_acc - w_prod;
            default: w_val = r_acc + w_prod;
        endcase
        // tie point (-1,-1) in fixed point
        w_tie = r_c - (VW'(w_a + w_b) <<< tbr_pkg::FRAC_BITS);
        w_e   = r_neg ? -w_val : w_val;
        w_t   = r_neg ? -w_tie : w_tie;
        w_ok  = !((w_e < 0) || (w_e > r_aa) || ((w_e == 0) && (w_t < 0)));
        w_x   = (r_bit == TOPBIT) ? {1'b0, VW'(r_e[r_j])} : {r_rem, 1'b0};
        w_ge  = (w_x >= {1'b0, VW'(r_aa)});
    end

    assign o_pop  = (r_state == S_IDLE) && i_qstat.valid;
    assign o_idle = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL || r_state == S_CMUL) begin
            r_prod <= w_m1 * w_m2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && !i_stall && (r_state != S_OUT)) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_qstat.valid) begin
                        r_px    <= i_pix.x;
                        r_py    <= i_pix.y;
                        r_last  <= i_pix.last;
                        r_cov   <= 1'b1;
                        r_rgb   <= '{8'd0, 8'd0, 8'd0};
                        r_pass  <= 2'd0;
                        r_term  <= 2'd0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc  <= w_val;
                    r_term <= r_term + 1'b1;
                    if (r_term == 2'd1) begin
                        r_c <= w_val;
                    end
                    if (r_term != 2'd3) begin
                        r_state <= S_MUL;
                    end else if (r_pass == 2'd0) begin
                        r_neg  <= (w_val < 0);
                        r_aa   <= (w_val < 0) ? -w_val : w_val;
                        r_pass <= 2'd1;
                        if (w_val == 0) begin
                            r_cov   <= 1'b0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end else begin
                        r_e[r_pass - 2'd1] <= w_e;
                        r_pass <= r_pass + 1'b1;
                        if (!w_ok) begin
                            r_cov <= 1'b0;
                        end
                        if (r_pass != 2'd3) begin
                            r_state <= S_MUL;
                        end else begin
                            r_j   <= 2'd0;
                            r_bit <= TOPBIT;
                            if (!(r_cov && w_ok)) begin
                                r_state <= S_OUT;
                            end else if (i_tri.smooth) begin
                                r_state <= S_DIV;
                            end else begin
                                r_rgb   <= '{i_tri.c[0][23:16], i_tri.c[0][15:8],
                                             i_tri.c[0][7:0]};
                                r_state <= S_OUT;
                            end
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= w_ge ? VW'(w_x - {1'b0, VW'(r_aa)}) : VW'(w_x);
                    r_q   <= {r_q[WW-2:0], w_ge};
                    if (r_bit != '0) begin
                        r_bit <= r_bit - 1'b1;
                    end else begin
                        r_w[r_j] <= {r_q[WW-2:0], w_ge};
                        r_bit    <= TOPBIT;
                        if (r_j == 2'd2) begin
                            r_j     <= 2'd0;
                            r_ch    <= 2'd0;
                            r_state <= S_CMUL;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
                S_CMUL: begin
                    r_state <= S_CACC;
                end
                S_CACC: begin
                    r_acc <= (r_j == 2'd0) ? w_prod : (r_acc + w_prod);
                    if (r_j != 2'd2) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_CMUL;
                    end else begin
                        r_rgb[r_ch] <= 8'((r_acc + w_prod) >>> 16);
                        r_j  <= 2'd0;
                        r_ch <= r_ch + 1'b1;
                        if (r_ch == 2'd2) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_CMUL;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ov || !i_stall) begin
                        r_ov    <= 1'b1;
                        r_ox    <= r_px;
                        r_oy    <= r_py;
                        r_ocov  <= r_cov;
                        r_olast <= r_last;
                        r_or    <= r_rgb[0];
                        r_og    <= r_rgb[1];
                        r_ob    <= r_rgb[2];
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_ov;
    assign o_pixel_x    = r_ox;
    assign o_pixel_y    = r_oy;
    assign o_covered    = r_ocov;
    assign o_red_out    = r_or;
    assign o_green_out  = r_og;
    assign o_blue_out   = r_ob;
    assign o_last_pixel = r_olast;

    `TBR_ASSERT_IMP(a_pop_nonempty, o_pop, i_qstat.valid, "pop from empty queue")
    `TBR_ASSERT_IMP(a_uncov_black, r_ov && !r_ocov, (r_or == 8'd0) && (r_og == 8'd0) && (r_ob == 8'd0), "uncovered pixel has colour")
    `TBR_ASSERT_IMP(a_rem_bound, (r_state == S_DIV) && (r_bit != TOPBIT), r_rem < VW'(r_aa), "divider remainder out of range")
    `TBR_ASSERT_NXT(a_out_to_idle, (r_state == S_OUT) && (!r_ov || !i_stall), r_ov && (r_state == S_IDLE), "result not registered")

endmodule
